// ----- rtl/core/wpt_pkg.sv -----
// Shared package of the WS2812B pixel transmitter.
// Holds register indexes, reset values, colour constants and the types
// passed between the front end, command queue and timing back end.
`default_nettype none

package wpt_pkg;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_GAP   = 3'd5;

   // Register reset values
   localparam logic [7:0]  RST_ONE_HIGH  = 8'd48;
   localparam logic [7:0]  RST_ONE_LOW   = 8'd14;
   localparam logic [7:0]  RST_ZERO_HIGH = 8'd14;
   localparam logic [7:0]  RST_ZERO_LOW  = 8'd48;
   localparam logic [15:0] RST_RESET_GAP = 16'd12000;

   // Frame and timing constants
   localparam int unsigned COLOR_W    = 24;
   localparam logic [4:0]  FRAME_BITS = 5'd24;
   localparam logic [15:0] GAP_MAX    = 16'hFFFF;

   // Channel levels used by the colour names
   localparam logic [7:0] CH_FULL   = 8'd255;
   localparam logic [7:0] CH_HALF   = 8'd128;
   localparam logic [7:0] CH_YELLOW = 8'd150;
   localparam logic [7:0] CH_ORANGE = 8'd75;
   localparam logic [7:0] CH_OFF    = 8'd0;
   localparam logic [7:0] BR_ROUND  = 8'h80;

   // ASCII codes of the name characters
   localparam logic [7:0] CHR_R_LC = 8'h72;
   localparam logic [7:0] CHR_R_UC = 8'h52;
   localparam logic [7:0] CHR_G_LC = 8'h67;
   localparam logic [7:0] CHR_G_UC = 8'h47;
   localparam logic [7:0] CHR_B_UC = 8'h42;
   localparam logic [7:0] CHR_U_LC = 8'h75;
   localparam logic [7:0] CHR_P_LC = 8'h70;
   localparam logic [7:0] CHR_Y_LC = 8'h79;
   localparam logic [7:0] CHR_O_LC = 8'h6F;
   localparam logic [7:0] CHR_W_LC = 8'h77;

   typedef struct packed {
      logic        enable;
      logic [7:0]  one_high;
      logic [7:0]  one_low;
      logic [7:0]  zero_high;
      logic [7:0]  zero_low;
      logic [15:0] reset_gap;
   } cfg_type;

   // One classified item: tick or set with its ready-made GRB word
   typedef struct packed {
      logic               is_set;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic set_accepted;
   } rsp_type;

endpackage : wpt_pkg

`default_nettype wire

// ----- rtl/core/wpt_front.sv -----
// Front end: accepts items, decodes colour names and applies brightness.
// Depends on wpt_pkg; feeds wpt_cmd_queue.
`default_nettype none

module wpt_front import wpt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_first_char,
   input  wire logic [7:0] req_third_char,
   input  wire logic [7:0] req_brightness,
   input  wire logic       q_full,
   output logic            cmd_valid,
   output cmd_type         cmd
);

   logic    front_valid_ff, front_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;
   logic    known;
   logic [7:0] ch_r, ch_g, ch_b;
   logic [7:0] sc_r, sc_g, sc_b;

   // Rounded brightness scaling of one channel
   function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] br);
      logic [15:0] prod;
      prod = ({8'd0, c} * {8'd0, br}) + {8'd0, BR_ROUND};
      return (br == CH_FULL) ? c : prod[15:8];
   endfunction

   // Colour name decode
   always_comb begin
      known = 1'b1;
      ch_r  = CH_OFF;
      ch_g  = CH_OFF;
      ch_b  = CH_OFF;
      if (req_first_char == CHR_R_LC || req_first_char == CHR_R_UC) begin
         ch_r = CH_FULL;
      end else if (req_first_char == CHR_G_LC || req_first_char == CHR_G_UC) begin
         ch_g = CH_FULL;
      end else if (req_first_char == CHR_B_UC || req_third_char == CHR_U_LC) begin
         ch_b = CH_FULL;
      end else if (req_first_char == CHR_P_LC) begin
         ch_r = CH_HALF;
         ch_b = CH_HALF;
      end else if (req_first_char == CHR_Y_LC) begin
         ch_r = CH_FULL;
         ch_g = CH_YELLOW;
      end else if (req_first_char == CHR_O_LC) begin
         ch_r = CH_FULL;
         ch_g = CH_ORANGE;
      end else if (req_first_char == CHR_W_LC) begin
         ch_r = CH_FULL;
         ch_g = CH_FULL;
         ch_b = CH_FULL;
      end else begin
         known = 1'b0;
      end
   end

   assign sc_r = scale(ch_r, req_brightness);
   assign sc_g = scale(ch_g, req_brightness);
   assign sc_b = scale(ch_b, req_brightness);

   // Input stage: holds while the command queue is full
   assign full = front_valid_ff & q_full;
   assign take = push & ~full;

   always_comb begin
      front_valid_in = take | (front_valid_ff & q_full);
      cmd_in         = cmd_ff;
      if (take) begin
         cmd_in.is_set = req_kind;
         if (!known || req_brightness == 8'd0) begin
            cmd_in.color = '0;
         end else begin
            cmd_in.color = {sc_g, sc_r, sc_b};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = front_valid_ff;
   assign cmd       = cmd_ff;

endmodule : wpt_front

`default_nettype wire

// ----- rtl/core/wpt_cmd_queue.sv -----
// Two-entry queue of classified items between front end and back end.
// Depends on wpt_pkg for cmd_type.
`default_nettype none

module wpt_cmd_queue import wpt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_en,
   input  cmd_type   wr_data,
   output logic      q_full,
   input  wire logic rd_en,
   output logic      rd_valid,
   output cmd_type   rd_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign q_full   = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en & ~q_full;
   assign do_rd    = rd_en & rd_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule : wpt_cmd_queue

`default_nettype wire

// ----- rtl/core/wpt_back.sv -----
// Back end: frame timing engine, pending colour slot and result queue.
// Depends on wpt_pkg; takes items from wpt_cmd_queue.
`default_nettype none

module wpt_back import wpt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  cfg_type   cfg,
   input  wire logic cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   input  wire logic rsp_pop,
   output logic      rsp_empty,
   output rsp_type   rsp
);

   // Line state
   logic [COLOR_W-1:0] pend_color_ff, pend_color_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [COLOR_W-1:0] shift_ff, shift_in;
   logic [4:0]         bits_left_ff, bits_left_in;
   logic               high_ff, high_in;
   logic [7:0]         phase_ff, phase_in;
   logic [15:0]        gap_ff, gap_in;
   logic               sent_ff, sent_in;
   logic [7:0]         phase_dec;
   rsp_type            res;

   // Result queue
   rsp_type    rq_ff [2];
   logic       rq_wr_ff, rq_wr_in;
   logic       rq_rd_ff, rq_rd_in;
   logic [1:0] rq_cnt_ff, rq_cnt_in;
   logic       rq_pop;

   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   function automatic logic [7:0] high_len(input logic top, input cfg_type c);
      return at_least_one(top ? c.one_high : c.zero_high);
   endfunction

   function automatic logic [7:0] low_len(input logic top, input cfg_type c);
      return at_least_one(top ? c.one_low : c.zero_low);
   endfunction

   // One item is executed per cycle while the result queue has room
   assign cmd_pop   = cmd_valid & (rq_cnt_ff != 2'd2);
   assign phase_dec = phase_ff - 8'd1;

   // Item execution: tick advances the line and starts a pending frame, set fills the pending slot if enabled and empty
   always_comb begin
      pend_color_in = pend_color_ff;
      pend_valid_in = pend_valid_ff;
      shift_in      = shift_ff;
      bits_left_in  = bits_left_ff;
      high_in       = high_ff;
      phase_in      = phase_ff;
      gap_in        = gap_ff;
      sent_in       = sent_ff;
      res.set_accepted = 1'b0;
      if (cmd.is_set) begin
         if (cfg.enable && !pend_valid_ff) begin
            pend_color_in    = cmd.color;
            pend_valid_in    = 1'b1;
            res.set_accepted = 1'b1;
         end
      end else begin
         // advance the running frame or the gap counter
         if (bits_left_ff != 5'd0) begin
            phase_in = phase_dec;
            if (phase_dec == 8'd0) begin
               if (high_ff) begin
                  high_in  = 1'b0;
                  phase_in = low_len(shift_ff[COLOR_W-1], cfg);
               end else begin
                  shift_in     = {shift_ff[COLOR_W-2:0], 1'b0};
                  bits_left_in = bits_left_ff - 5'd1;
                  if (bits_left_ff == 5'd1) begin
                     sent_in = 1'b1;
                     gap_in  = 16'd0;
                  end else begin
                     high_in  = 1'b1;
                     phase_in = high_len(shift_ff[COLOR_W-2], cfg);
                  end
               end
            end
         end else if (gap_ff != GAP_MAX) begin
            gap_in = gap_ff + 16'd1;
         end
         // start a pending frame once the gap is met, or at once before the first frame
         if (bits_left_in == 5'd0 && pend_valid_ff &&
             (!sent_in || gap_in >= cfg.reset_gap)) begin
            shift_in      = pend_color_ff;
            pend_valid_in = 1'b0;
            bits_left_in  = FRAME_BITS;
            high_in       = 1'b1;
            phase_in      = high_len(pend_color_ff[COLOR_W-1], cfg);
         end
      end
      res.line_level = (bits_left_in != 5'd0) & high_in;
      res.busy_res   = pend_valid_in | (bits_left_in != 5'd0);
   end

   // Result queue bookkeeping
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign rsp       = rq_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop & ~rsp_empty;

   always_comb begin
      rq_wr_in  = cmd_pop ? ~rq_wr_ff : rq_wr_ff;
      rq_rd_in  = rq_pop ? ~rq_rd_ff : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (cmd_pop && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 2'd1;
      end else if (rq_pop && !cmd_pop) begin
         rq_cnt_in = rq_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_color_ff <= '0;
         pend_valid_ff <= 1'b0;
         shift_ff      <= '0;
         bits_left_ff  <= 5'd0;
         high_ff       <= 1'b0;
         phase_ff      <= 8'd0;
         gap_ff        <= 16'd0;
         sent_ff       <= 1'b0;
         rq_wr_ff      <= 1'b0;
         rq_rd_ff      <= 1'b0;
         rq_cnt_ff     <= 2'd0;
      end else begin
         if (cmd_pop) begin
            pend_color_ff <= pend_color_in;
            pend_valid_ff <= pend_valid_in;
            shift_ff      <= shift_in;
            bits_left_ff  <= bits_left_in;
            high_ff       <= high_in;
            phase_ff      <= phase_in;
            gap_ff        <= gap_in;
            sent_ff       <= sent_in;
         end
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
      if (cmd_pop) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

endmodule : wpt_back

`default_nettype wire

// ----- rtl/core/ws2812b_pixel_transmitter.sv -----
// Top level of the WS2812B pixel transmitter: configuration registers and
// the chain front end -> command queue -> timing back end. Uses wpt_pkg.
`default_nettype none

// Every accepted item (tick or set colour) yields exactly one result, in
// order. The block sustains one item per clock: push may be held high every
// cycle and full stays low as long as pop keeps up. A result reaches the
// result ports through the input register, then the command queue, then
// the result queue written by the timing engine; two-entry queues on each
// side absorb short stalls. The timing engine updates the whole line state
// for each item in one step, which sets the one-item-per-clock rate.
// Registers are written at any edge with csr_we high and should only be
// changed while the block is idle.
module ws2812b_pixel_transmitter import wpt_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // item input
   input  wire logic                   push,
   output logic                        full,
   input  wire logic                   req_kind,
   input  wire logic [7:0]             req_first_char,
   input  wire logic [7:0]             req_third_char,
   input  wire logic [7:0]             req_brightness,
   // results
   output logic                        empty,
   input  wire logic                   pop,
   output logic                        rsp_line_level,
   output logic                        rsp_busy_res,
   output logic                        rsp_set_accepted,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    front_valid;
   cmd_type front_cmd;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   rsp_type rsp;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    cfg_in.enable    = csr_wdata[0];
            CSR_ONE_HIGH:  cfg_in.one_high  = csr_wdata[7:0];
            CSR_ONE_LOW:   cfg_in.one_low   = csr_wdata[7:0];
            CSR_ZERO_HIGH: cfg_in.zero_high = csr_wdata[7:0];
            CSR_ZERO_LOW:  cfg_in.zero_low  = csr_wdata[7:0];
            CSR_RESET_GAP: cfg_in.reset_gap = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b0;
         cfg_ff.one_high  <= RST_ONE_HIGH;
         cfg_ff.one_low   <= RST_ONE_LOW;
         cfg_ff.zero_high <= RST_ZERO_HIGH;
         cfg_ff.zero_low  <= RST_ZERO_LOW;
         cfg_ff.reset_gap <= RST_RESET_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wpt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_first_char (req_first_char),
      .req_third_char (req_third_char),
      .req_brightness (req_brightness),
      .q_full         (q_full),
      .cmd_valid      (front_valid),
      .cmd            (front_cmd)
   );

   wpt_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_valid),
      .wr_data  (front_cmd),
      .q_full   (q_full),
      .rd_en    (cmd_pop),
      .rd_valid (cmd_valid),
      .rd_data  (cmd)
   );

   wpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp       (rsp)
   );

   assign rsp_line_level   = rsp.line_level;
   assign rsp_busy_res     = rsp.busy_res;
   assign rsp_set_accepted = rsp.set_accepted;

`ifndef NO_ASSERTIONS
   // a queued colour always shows as busy in the same result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_set_accepted) |-> rsp_busy_res)
      else $error("set accepted without busy");

   // the line is only driven high while a frame is in flight
   a_line_busy: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_line_level) |-> rsp_busy_res)
      else $error("line high while not busy");

   // input side is open straight after reset
   a_open_after_reset: assert property (@(posedge clock)
      reset |=> !full)
      else $error("full set after reset");

   // command queue never pops when it holds nothing
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("back end took an item from an empty queue");
`endif

endmodule : ws2812b_pixel_transmitter

`default_nettype wire
